// ----- rtl/core/guard_page_table_walker_core_defines.svh -----
// Assertion helpers for the page-table walker core.
`ifndef GUARD_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define GUARD_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

// Check on every edge outside reset.
`define GPTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define GPTW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/gptw_pkg.sv -----
package gptw_pkg;

    localparam int DEF_STORE_PAGES = 8;
    localparam int LEVELS          = 4;
    localparam int LVL_W           = 2;
    localparam int PAGE_WORDS      = 512;
    localparam int PAGE_IDX_W      = 9;

    localparam int OP_W     = 2;
    localparam int WIDX_W   = 12;
    localparam int WORD_W   = 64;
    localparam int VA_W     = 48;
    localparam int ROOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int VPN_W    = 36;

    localparam int ADDR_LO  = 12;
    localparam int ADDR_HI  = 51;
    localparam int PFN_W    = ADDR_HI - ADDR_LO + 1;
    localparam int PRESENT  = 0;

    localparam int LEVEL_SHIFT [LEVELS] = '{39, 30, 21, 12};

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_GUARD = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE         = 2'd0,
        ST_NOT_PRESENT  = 2'd1,
        ST_OUT_OF_STORE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RD,
        S_RDW,
        S_CHECK,
        S_WAIT,
        S_WB,
        S_RESP
    } t_state;

    function automatic logic [PAGE_IDX_W-1:0] level_index(
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] lvl
    );
        logic [VA_W-1:0] s;
        s = va >> LEVEL_SHIFT[lvl];
        return s[PAGE_IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/gptw_in_if.sv -----
interface gptw_in_if;
    import gptw_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] entry_data;
    logic [VA_W-1:0]   virtual_address;

    modport source (output valid, opcode, word_index, entry_data, virtual_address,
                    input ready);
    modport sink   (input valid, opcode, word_index, entry_data, virtual_address,
                    output ready);
endinterface

// ----- rtl/core/gptw_out_if.sv -----
interface gptw_out_if;
    import gptw_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_data;
    logic [LVL_W-1:0]    stop_level;
    logic                invalidate_valid;
    logic [VPN_W-1:0]    invalidate_page;

    modport source (output valid, status, read_data, stop_level, invalidate_valid,
                    invalidate_page, input ready);
    modport sink   (input valid, status, read_data, stop_level, invalidate_valid,
                    invalidate_page, output ready);
endinterface

// ----- rtl/core/gptw_cfg_if.sv -----
interface gptw_cfg_if;
    import gptw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root_table_page;

    modport source (output valid, root_table_page, input ready);
    modport sink   (input valid, root_table_page, output ready);
endinterface

// ----- rtl/core/gptw_ram.sv -----
module gptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/guard_page_table_walker_core.sv -----
// A write passes S_WRITE then S_RESP, a read S_RD, S_RDW then S_RESP; a guard walk takes
// S_CHECK and S_WAIT per level read, S_WB for a leaf write-back, then S_RESP, and an
// outside page goes from S_CHECK straight to S_RESP. One item at a time: the next word
// is taken in the cycle after the result is loaded; the single store port carries each
// level's read and the leaf write-back. Reset: the store is cleared one word a cycle,
// with no input word taken meanwhile; root_table_page resets to 0 and is writable at once.
`include "guard_page_table_walker_core_defines.svh"

module guard_page_table_walker_core #(
    parameter int STORE_PAGES = gptw_pkg::DEF_STORE_PAGES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gptw_in_if.sink      i_in,
    gptw_out_if.source   o_out,
    gptw_cfg_if.sink     i_cfg
);
    import gptw_pkg::*;

    localparam int STORE_WORDS = STORE_PAGES * PAGE_WORDS;
    localparam int PW = $clog2(STORE_PAGES);
    localparam int AW = PW + PAGE_IDX_W;
    localparam int CW = (AW > WIDX_W) ? AW : WIDX_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr;
    logic [ROOT_W-1:0]   r_root;

    t_op                 r_op;
    logic [WIDX_W-1:0]   r_widx;
    logic [WORD_W-1:0]   r_data;
    logic [VA_W-1:0]     r_va;
    logic [PFN_W-1:0]    r_page;
    logic [LVL_W-1:0]    r_lvl;
    logic [LVL_W-1:0]    r_stop;
    logic [AW-1:0]       r_slot;
    logic [WORD_W-1:0]   r_ent;

    t_status             r_res_status;
    logic [WORD_W-1:0]   r_res_rdata;
    logic [LVL_W-1:0]    r_res_stop;
    logic                r_res_inv;
    logic [VPN_W-1:0]    r_res_vpn;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [WORD_W-1:0]   r_out_rdata;
    logic [LVL_W-1:0]    r_out_stop;
    logic                r_out_inv;
    logic [VPN_W-1:0]    r_out_vpn;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    logic                in_accept;
    logic                res_load;
    logic [CW-1:0]       widx_ext;
    logic                widx_in_store;
    logic [AW-1:0]       slot;
    logic                page_oob;
    logic                ent_present;
    logic                at_leaf;

    gptw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign in_accept     = i_in.valid && i_in.ready;
    assign res_load      = (r_state == S_RESP) && (!r_out_valid || o_out.ready);
    assign widx_ext      = CW'(r_widx);
    assign widx_in_store = {1'b0, widx_ext} < (CW + 1)'(STORE_WORDS);
    assign slot          = {r_page[PW-1:0], level_index(r_va, r_lvl)};
    assign page_oob      = r_page >= PFN_W'(STORE_PAGES);
    assign ent_present   = ram_rdata[PRESENT];
    assign at_leaf       = r_lvl == LVL_W'(LEVELS - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (t_op'(i_in.opcode))
                        OP_WRITE: n_state = S_WRITE;
                        OP_READ:  n_state = S_RD;
                        OP_GUARD: n_state = S_CHECK;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_WRITE: n_state = S_RESP;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_RESP;
            S_CHECK: n_state = page_oob ? S_RESP : S_WAIT;
            S_WAIT: begin
                if (!ent_present) begin
                    n_state = S_RESP;
                end else if (at_leaf) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_WB:    n_state = S_RESP;
            S_RESP: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = slot;
        ram_wdata = r_data;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_WRITE: begin
                ram_we   = widx_in_store;
                ram_addr = widx_ext[AW-1:0];
            end
            S_RD: begin
                ram_addr = widx_ext[AW-1:0];
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_addr  = r_slot;
                ram_wdata = r_ent & ~(WORD_W'(1) << PRESENT);
            end
            default: begin
                ram_addr = slot;
            end
        endcase
    end

    assign i_in.ready             = r_state == S_IDLE;
    assign i_cfg.ready            = 1'b1;
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out_status;
    assign o_out.read_data        = r_out_rdata;
    assign o_out.stop_level       = r_out_stop;
    assign o_out.invalidate_valid = r_out_inv;
    assign o_out.invalidate_page  = r_out_vpn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_root <= i_cfg.root_table_page;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_op         <= t_op'(i_in.opcode);
                    r_widx       <= i_in.word_index;
                    r_data       <= i_in.entry_data;
                    r_va         <= i_in.virtual_address;
                    r_page       <= PFN_W'(r_root);
                    r_lvl        <= '0;
                    r_stop       <= '0;
                    r_res_status <= ST_DONE;
                    r_res_rdata  <= '0;
                    r_res_stop   <= '0;
                    r_res_inv    <= 1'b0;
                    r_res_vpn    <= '0;
                end
            end
            S_RDW: begin
                r_res_rdata <= widx_in_store ? ram_rdata : '0;
            end
            S_CHECK: begin
                r_slot <= slot;
                if (page_oob) begin
                    r_res_status <= ST_OUT_OF_STORE;
                    r_res_stop   <= r_stop;
                end
            end
            S_WAIT: begin
                r_ent      <= ram_rdata;
                r_res_stop <= r_lvl;
                if (!ent_present) begin
                    r_res_status <= ST_NOT_PRESENT;
                end else if (at_leaf) begin
                    r_res_inv <= 1'b1;
                    r_res_vpn <= r_va[VA_W-1:ADDR_LO];
                end else begin
                    r_page <= ram_rdata[ADDR_HI:ADDR_LO];
                    r_stop <= r_lvl;
                    r_lvl  <= r_lvl + LVL_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (res_load) begin
            r_out_status <= r_res_status;
            r_out_rdata  <= r_res_rdata;
            r_out_stop   <= r_res_stop;
            r_out_inv    <= r_res_inv;
            r_out_vpn    <= r_res_vpn;
        end
    end

    `GPTW_ASSERT(a_inv_only_when_done,
        o_out.valid && o_out.invalidate_valid |-> o_out.status == ST_DONE,
        "invalidate reported on a walk that did not finish")
    `GPTW_ASSERT(a_writeback_at_leaf,
        r_state == S_WB |-> at_leaf && r_op == OP_GUARD && r_ent[PRESENT],
        "write-back of an entry that is not a present leaf")
    `GPTW_ASSERT(a_clear_ends,
        r_state == S_CLEAR && r_clr == LAST_WORD |=> r_state == S_IDLE,
        "store clearing did not end after the last word")
    `GPTW_ASSERT(a_read_data_only_on_read,
        o_out.valid && o_out.read_data != '0 |-> !o_out.invalidate_valid
            && o_out.stop_level == '0 && o_out.status == ST_DONE,
        "read data present on a result that is not a read")
    `GPTW_ASSERT_ALWAYS(a_no_accept_in_reset,
        !i_rst_n |=> !i_in.ready,
        "input taken right after reset while the store is being cleared")

endmodule

// ----- bench/gptw_checker.sv -----
module gptw_checker #(
    parameter int STORE_PAGES = gptw_pkg::DEF_STORE_PAGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gptw_in_if   word_in,
    gptw_out_if  word_out,
    gptw_cfg_if  root_cfg,
    output int   o_mismatches,
    output int   o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import gptw_pkg::*;

    localparam int STORE_WORDS = STORE_PAGES * PAGE_WORDS;
    localparam int PRINT_CAP   = 100;

    typedef struct {
        t_status           status;
        logic [WORD_W-1:0] read_data;
        logic [LVL_W-1:0]  stop_level;
        logic              inv_valid;
        logic [VPN_W-1:0]  inv_page;
    } t_outcome;

    logic [WORD_W-1:0] shadow_tables [STORE_WORDS];
    logic [ROOT_W-1:0] root_page;
    t_outcome          outcomes_due [$];
    int                mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic t_outcome predict_outcome(
        input t_op               op,
        input logic [WIDX_W-1:0] widx,
        input logic [WORD_W-1:0] data,
        input logic [VA_W-1:0]   va
    );
        t_outcome        res;
        logic [PFN_W-1:0] page;
        logic [VA_W-1:0] shifted;
        int              slot;
        int              lvl;
        res = '{ST_DONE, '0, '0, 1'b0, '0};
        case (op)
            OP_WRITE: begin
                if (widx < STORE_WORDS) shadow_tables[widx] = data;
            end
            OP_READ: begin
                if (widx < STORE_WORDS) res.read_data = shadow_tables[widx];
            end
            OP_GUARD: begin
                page = PFN_W'(root_page);
                if (page >= STORE_PAGES) begin
                    res.status = ST_OUT_OF_STORE;
                    return res;
                end
                for (lvl = 0; lvl < LEVELS; lvl++) begin
                    shifted        = va >> LEVEL_SHIFT[lvl];
                    slot           = int'(page) * PAGE_WORDS + int'(shifted[PAGE_IDX_W-1:0]);
                    res.stop_level = LVL_W'(lvl);
                    if (!shadow_tables[slot][PRESENT]) begin
                        res.status = ST_NOT_PRESENT;
                        return res;
                    end
                    if (lvl == LEVELS - 1) begin
                        shadow_tables[slot][PRESENT] = 1'b0;
                        res.inv_valid = 1'b1;
                        res.inv_page  = va[VA_W-1:ADDR_LO];
                        return res;
                    end
                    page = shadow_tables[slot][ADDR_HI:ADDR_LO];
                    if (page >= STORE_PAGES) begin
                        res.status = ST_OUT_OF_STORE;
                        return res;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_outcome();
        t_outcome want;
        if (outcomes_due.size() == 0) begin
            report_mismatch($sformatf("result word with none pending, status %0d",
                                      word_out.status));
            return;
        end
        want = outcomes_due.pop_front();
        if (word_out.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      word_out.status, want.status));
        if (word_out.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      word_out.read_data, want.read_data));
        if (word_out.stop_level !== want.stop_level)
            report_mismatch($sformatf("stop_level got %0d want %0d",
                                      word_out.stop_level, want.stop_level));
        if (word_out.invalidate_valid !== want.inv_valid)
            report_mismatch($sformatf("invalidate_valid got %b want %b",
                                      word_out.invalidate_valid, want.inv_valid));
        if (word_out.invalidate_page !== want.inv_page)
            report_mismatch($sformatf("invalidate_page got %h want %h",
                                      word_out.invalidate_page, want.inv_page));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_tables[w]) shadow_tables[w] = '0;
            root_page = '0;
            outcomes_due.delete();
        end else begin
            if (root_cfg.valid && root_cfg.ready) root_page = root_cfg.root_table_page;
            if (word_in.valid && word_in.ready) begin
                outcomes_due.push_back(predict_outcome(t_op'(word_in.opcode),
                                                       word_in.word_index,
                                                       word_in.entry_data,
                                                       word_in.virtual_address));
            end
            if (word_out.valid && word_out.ready) check_outcome();
        end
        o_results_due <= outcomes_due.size();
    end

endmodule

// ----- bench/tb_guard_page_table_walker_core.sv -----
module tb_guard_page_table_walker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gptw_pkg::*;

    localparam int STORE_PAGES   = DEF_STORE_PAGES;
    localparam int PHASE_ITEMS   = 470;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    gptw_in_if  word_in();
    gptw_out_if word_out();
    gptw_cfg_if root_cfg();

    int                idle_pct   = 0;
    int                stall_pct  = 0;
    int                items_sent = 0;
    int                mismatches;
    int                results_due;
    int                cycle_count;
    logic [ROOT_W-1:0] root_now = '0;
    logic [VA_W-1:0]   last_va  = '0;
    logic [WIDX_W-1:0] last_widx = '0;

    guard_page_table_walker_core #(
        .STORE_PAGES(STORE_PAGES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (word_in),
        .o_out  (word_out),
        .i_cfg  (root_cfg)
    );

    gptw_checker #(
        .STORE_PAGES(STORE_PAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .word_in      (word_in),
        .word_out     (word_out),
        .root_cfg     (root_cfg),
        .o_mismatches (mismatches),
        .o_results_due(results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        word_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [WIDX_W-1:0] slot_of(input int page, input int lvl,
                                                  input logic [VA_W-1:0] va);
        logic [VA_W-1:0] s;
        s = va >> LEVEL_SHIFT[lvl];
        return WIDX_W'(page * PAGE_WORDS) + WIDX_W'(s[PAGE_IDX_W-1:0]);
    endfunction

    function automatic logic [WORD_W-1:0] entry_word(input logic [PFN_W-1:0] pfn,
                                                     input logic present,
                                                     input logic [WORD_W-1:0] fill);
        logic [WORD_W-1:0] e;
        e                 = fill;
        e[ADDR_HI:ADDR_LO] = pfn;
        e[PRESENT]        = present;
        return e;
    endfunction

    function automatic logic [PFN_W-1:0] outside_pfn();
        logic [PFN_W-1:0] p;
        case ($urandom_range(2))
            0:       p = PFN_W'(STORE_PAGES + $urandom_range(7));
            1:       p = '1;
            default: begin
                p = {8'($urandom), 32'($urandom)};
                if (p < STORE_PAGES) p = p + PFN_W'(STORE_PAGES);
            end
        endcase
        return p;
    endfunction

    task automatic send_word(input t_op op, input logic [WIDX_W-1:0] widx,
                             input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va);
        while ($urandom_range(99) < idle_pct) begin
            word_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_in.valid           <= 1'b1;
        word_in.opcode          <= op;
        word_in.word_index      <= widx;
        word_in.entry_data      <= data;
        word_in.virtual_address <= va;
        do @(posedge i_clk); while (!word_in.ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        word_in.valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    task automatic write_root(input logic [ROOT_W-1:0] page);
        root_cfg.valid           <= 1'b1;
        root_cfg.root_table_page <= page;
        do @(posedge i_clk); while (!root_cfg.ready);
        root_cfg.valid <= 1'b0;
        root_now = page;
    endtask

    // root page 0; chain for the all-ones address runs pages 0 -> 3 -> 5 -> 7
    task automatic directed_checks();
        send_word(OP_READ, '0, '0, '0);
        send_word(OP_READ, '1, '0, '0);
        send_word(OP_WRITE, '1, '1, '0);
        send_word(OP_READ, '1, '1, '1);
        send_word(OP_NOP, '1, '1, '1);
        send_word(OP_GUARD, '0, '0, '0);
        send_word(OP_WRITE, slot_of(0, 0, '1), entry_word(PFN_W'(3), 1'b1, '1), '0);
        send_word(OP_WRITE, slot_of(3, 1, '1), entry_word(PFN_W'(5), 1'b1, '1), '0);
        send_word(OP_WRITE, slot_of(5, 2, '1), entry_word(PFN_W'(7), 1'b1, '1), '0);
        send_word(OP_GUARD, '0, '0, '1);
        send_word(OP_READ, slot_of(7, 3, '1), '0, '0);
        send_word(OP_GUARD, '1, '1, '1);
        send_word(OP_WRITE, slot_of(5, 2, '1),
                  entry_word(PFN_W'(STORE_PAGES), 1'b1, '0), '0);
        send_word(OP_GUARD, '0, '0, '1);
        send_word(OP_WRITE, slot_of(0, 0, '1), '1, '0);
        send_word(OP_GUARD, '0, '0, '1);
        send_word(OP_WRITE, slot_of(0, 0, '0), entry_word(PFN_W'(1), 1'b1, '0), '0);
        send_word(OP_GUARD, '0, '0, '0);
        send_word(OP_NOP, '0, '0, '0);
    endtask

    task automatic guard_sequence();
        logic [VA_W-1:0]   va;
        logic [PFN_W-1:0]  nxt;
        logic [WIDX_W-1:0] slot;
        int                page;
        int                kind;
        int                lvl;
        bit                ended;
        if ($urandom_range(3) == 0) begin
            va = last_va ^ (VA_W'(1) << $urandom_range(VA_W - 1));
        end else begin
            va = rand_va();
        end
        last_va = va;
        page    = int'(root_now);
        ended   = 1'b0;
        for (lvl = 0; lvl < LEVELS && !ended; lvl++) begin
            slot = slot_of(page, lvl, va);
            kind = $urandom_range(99);
            if (kind < 6) begin
                send_word(OP_WRITE, slot,
                          entry_word(PFN_W'(rand_word()), 1'b0, rand_word()), va);
                ended = 1'b1;
            end else if (kind < 12 && lvl < LEVELS - 1) begin
                send_word(OP_WRITE, slot, entry_word(outside_pfn(), 1'b1, rand_word()), va);
                ended = 1'b1;
            end else if (kind < 18) begin
                ended = 1'b1;
            end else begin
                nxt = PFN_W'($urandom_range(STORE_PAGES - 1));
                send_word(OP_WRITE, slot, entry_word(nxt, 1'b1, rand_word()), rand_va());
                page = int'(nxt);
            end
            last_widx = slot;
        end
        send_word(OP_GUARD, WIDX_W'($urandom), rand_word(), va);
        if ($urandom_range(2) == 0) send_word(OP_READ, last_widx, rand_word(), rand_va());
        if ($urandom_range(4) == 0) send_word(OP_GUARD, WIDX_W'($urandom), rand_word(), va);
    endtask

    task automatic run_phase(input int target);
        int                pick;
        logic [WIDX_W-1:0] widx;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                guard_sequence();
            end else if (pick < 70) begin
                widx = WIDX_W'($urandom);
                send_word(OP_WRITE, widx, rand_word(), rand_va());
                last_widx = widx;
            end else if (pick < 85) begin
                widx = ($urandom_range(1) == 0) ? last_widx : WIDX_W'($urandom);
                send_word(OP_READ, widx, rand_word(), rand_va());
            end else if (pick < 95) begin
                send_word(OP_GUARD, WIDX_W'($urandom), rand_word(),
                          ($urandom_range(1) == 0) ? last_va : rand_va());
            end else begin
                send_word(OP_NOP, WIDX_W'($urandom), rand_word(), rand_va());
            end
        end
    endtask

    initial begin
        int phase;
        int target;
        i_rst_n                 <= 1'b0;
        word_in.valid           <= 1'b0;
        word_in.opcode          <= OP_NOP;
        word_in.word_index      <= '0;
        word_in.entry_data      <= '0;
        word_in.virtual_address <= '0;
        root_cfg.valid          <= 1'b0;
        root_cfg.root_table_page <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_root('0);
        directed_checks();

        target = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    write_root(3'd7);
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    write_root(ROOT_W'($urandom_range(7)));
                    idle_pct  = 54;
                    stall_pct <= 0;
                end
                2: begin
                    write_root('0);
                    idle_pct  = 0;
                    stall_pct <= 54;
                end
                default: begin
                    write_root(ROOT_W'($urandom_range(7)));
                    idle_pct  = 33;
                    stall_pct <= 33;
                end
            endcase
            target = target + PHASE_ITEMS;
            run_phase(target);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- guard_page_table_walker_core.f -----
+incdir+rtl/core
rtl/core/gptw_pkg.sv
rtl/core/gptw_in_if.sv
rtl/core/gptw_out_if.sv
rtl/core/gptw_cfg_if.sv
rtl/core/gptw_ram.sv
rtl/core/guard_page_table_walker_core.sv
bench/gptw_checker.sv
bench/tb_guard_page_table_walker_core.sv
